>>> rtl/rt_bandwidth_admission_control_macros.svh
// assertion macros for the bandwidth admission control block
// used by the top level only, no other dependencies
`ifndef RT_BANDWIDTH_ADMISSION_CONTROL_MACROS_SVH
`define RT_BANDWIDTH_ADMISSION_CONTROL_MACROS_SVH

// same-cycle implication
`define BAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bandwidth admission control: check failed");

// next-cycle implication
`define BAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bandwidth admission control: check failed");

`endif

>>> rtl/bac_pkg.sv
// types, codes and constants for the bandwidth admission control block
// no dependencies
package bac_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int FIELD_W           = 32;
    localparam int UTIL_W            = 10;
    localparam int PRIO_W            = 5;
    localparam int CFG_INDEX_W       = 2;
    localparam int UTIL_SCALE        = 1000;

    localparam logic [UTIL_W-1:0] EDF_LIMIT_RST = 10'd1000;
    localparam logic [UTIL_W-1:0] RMS_LIMIT_RST = 10'd690;

    localparam int PERIOD_BAND_0 = 10;
    localparam int PERIOD_BAND_1 = 50;
    localparam int PERIOD_BAND_2 = 100;

    localparam logic [PRIO_W-1:0] PRIO_BAND_0 = 5'd30;
    localparam logic [PRIO_W-1:0] PRIO_BAND_1 = 5'd25;
    localparam logic [PRIO_W-1:0] PRIO_BAND_2 = 5'd20;
    localparam logic [PRIO_W-1:0] PRIO_BAND_3 = 5'd15;
    localparam logic [PRIO_W-1:0] PRIO_NONE   = 5'd0;

    localparam logic CMD_EDF = 1'b0;
    localparam logic CMD_RMS = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_EDF_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RMS_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_INVALID  = 2'd1,
        ST_EXCEEDED = 2'd2
    } bac_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_BUDGET,
        S_OUT
    } bac_state_t;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] exec_time;
        logic [FIELD_W-1:0] task_period;
        logic [FIELD_W-1:0] rel_deadline;
    } bac_req_t;

    typedef struct packed {
        bac_status_t       status;
        logic [PRIO_W-1:0] assigned_priority;
        logic [UTIL_W-1:0] utilization;
    } bac_rsp_t;

endpackage

>>> rtl/bac_util_div.sv
// iterative restoring divider: floor(w * 1000 / p) for w <= p, one quotient bit a cycle
// depends on bac_pkg
module bac_util_div #(
    parameter int TIME_W = bac_pkg::FIELD_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [TIME_W-1:0]          w,
    input  logic [TIME_W-1:0]          p,
    output logic                       done,
    output logic [bac_pkg::UTIL_W-1:0] q
);
    import bac_pkg::*;

    localparam int NW    = TIME_W + UTIL_W;
    localparam int CNT_W = $clog2(UTIL_W);

    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     d_reg, d_next;
    logic [UTIL_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NW:0]       diff;
    logic              ge;

    // shared subtract and compare
    assign diff = {1'b0, n_reg} - {1'b0, d_reg};
    assign ge   = !diff[NW];

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = NW'(w) * NW'(UTIL_SCALE);
            d_next    = NW'(p) << (UTIL_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(UTIL_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                n_next = diff[NW-1:0];
            end
            q_next = {q_reg[UTIL_W-2:0], ge};
            d_next = d_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        d_reg <= d_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

>>> rtl/rt_bandwidth_admission_control.sv
// bandwidth admission control for real-time tasks, one request at a time
// valid request: check, divide, budget, then result valid; invalid request: check, then result valid
// a new request is taken only after the result has been taken and the block is back in idle;
// a valid one goes through the ten steps of the shared divide unit plus the check, done, budget and output steps
// reset clears budget and latched limit, limit registers to 1000 and 690; no clearing pass
// depends on bac_pkg, bac_util_div and the macros header
`include "rt_bandwidth_admission_control_macros.svh"

module rt_bandwidth_admission_control #(
    parameter int TIME_BITS = bac_pkg::TIME_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  bac_pkg::bac_req_t               req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output bac_pkg::bac_rsp_t               rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bac_pkg::UTIL_W-1:0]      cfg_data
);
    import bac_pkg::*;

    localparam int TW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;

    bac_state_t        state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic [TW-1:0]     w_reg, w_next;
    logic [TW-1:0]     p_reg, p_next;
    logic [TW-1:0]     d_reg, d_next;
    logic [UTIL_W-1:0] util_reg, util_next;
    bac_rsp_t          rsp_reg, rsp_next;
    logic [UTIL_W-1:0] edf_limit_reg, edf_limit_next;
    logic [UTIL_W-1:0] rms_limit_reg, rms_limit_next;
    logic [UTIL_W-1:0] budget_used_reg, budget_used_next;
    logic [UTIL_W-1:0] budget_limit_reg, budget_limit_next;

    logic              bad;
    logic              div_start;
    logic              div_done;
    logic [UTIL_W-1:0] div_q;
    logic [UTIL_W-1:0] limit_eff;
    logic [UTIL_W:0]   budget_sum;
    logic [PRIO_W-1:0] prio;

    bac_util_div #(
        .TIME_W (TW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .w     (w_reg),
        .p     (p_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // parameter checks
    always_comb
    begin
        if (cmd_reg == CMD_RMS)
        begin
            bad = (p_reg == '0) || (w_reg > p_reg);
        end
        else
        begin
            bad = (p_reg == '0) || (w_reg == '0) || (w_reg > d_reg) || (d_reg > p_reg);
        end
    end

    assign limit_eff  = (budget_limit_reg != '0) ? budget_limit_reg :
                        ((cmd_reg == CMD_RMS) ? rms_limit_reg : edf_limit_reg);
    assign budget_sum = {1'b0, budget_used_reg} + {1'b0, util_reg};

    always_comb
    begin
        if (cmd_reg != CMD_RMS)
        begin
            prio = PRIO_NONE;
        end
        else if (p_reg <= TW'(PERIOD_BAND_0))
        begin
            prio = PRIO_BAND_0;
        end
        else if (p_reg <= TW'(PERIOD_BAND_1))
        begin
            prio = PRIO_BAND_1;
        end
        else if (p_reg <= TW'(PERIOD_BAND_2))
        begin
            prio = PRIO_BAND_2;
        end
        else
        begin
            prio = PRIO_BAND_3;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = bad ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_BUDGET;
                end
            end
            S_BUDGET:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:   req_ready = 1'b1;
            S_CHECK:  div_start = !bad;
            S_OUT:    rsp_valid = 1'b1;
            default:  ;
        endcase
    end

    // datapath and budget state
    always_comb
    begin
        cmd_next          = cmd_reg;
        w_next            = w_reg;
        p_next            = p_reg;
        d_next            = d_reg;
        util_next         = util_reg;
        rsp_next          = rsp_reg;
        budget_used_next  = budget_used_reg;
        budget_limit_next = budget_limit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req.command;
                    w_next   = req.exec_time[TW-1:0];
                    p_next   = req.task_period[TW-1:0];
                    d_next   = req.rel_deadline[TW-1:0];
                end
            end
            S_CHECK:
            begin
                if (bad)
                begin
                    rsp_next.status            = ST_INVALID;
                    rsp_next.assigned_priority = PRIO_NONE;
                    rsp_next.utilization       = '0;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    util_next = div_q;
                end
            end
            S_BUDGET:
            begin
                budget_limit_next    = limit_eff;
                rsp_next.utilization = util_reg;
                if (budget_sum > {1'b0, limit_eff})
                begin
                    rsp_next.status            = ST_EXCEEDED;
                    rsp_next.assigned_priority = PRIO_NONE;
                end
                else
                begin
                    budget_used_next           = budget_sum[UTIL_W-1:0];
                    rsp_next.status            = ST_ADMITTED;
                    rsp_next.assigned_priority = prio;
                end
            end
            default:  ;
        endcase
    end

    // limit registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        edf_limit_next = edf_limit_reg;
        rms_limit_next = rms_limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EDF_LIMIT: edf_limit_next = cfg_data;
                CFG_RMS_LIMIT: rms_limit_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            edf_limit_reg    <= EDF_LIMIT_RST;
            rms_limit_reg    <= RMS_LIMIT_RST;
            budget_used_reg  <= '0;
            budget_limit_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            edf_limit_reg    <= edf_limit_next;
            rms_limit_reg    <= rms_limit_next;
            budget_used_reg  <= budget_used_next;
            budget_limit_reg <= budget_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        w_reg    <= w_next;
        p_reg    <= p_next;
        d_reg    <= d_next;
        util_reg <= util_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp = rsp_reg;

    `BAC_ASSERT_IMP(a_budget_in_limit, clk, rst_n,
        budget_limit_reg != '0, budget_used_reg <= budget_limit_reg)
    `BAC_ASSERT_IMP(a_one_at_a_time, clk, rst_n, rsp_valid, !req_ready)
    `BAC_ASSERT_NXT(a_budget_only_on_decision, clk, rst_n,
        state_reg != S_BUDGET, $stable(budget_used_reg))
    `BAC_ASSERT_IMP(a_rms_admit_has_prio, clk, rst_n,
        rsp_valid && (rsp.status == ST_ADMITTED) && (cmd_reg == CMD_RMS),
        rsp.assigned_priority != PRIO_NONE)

endmodule
